[rtl/ritoa_pkg.sv]
// ritoa_pkg: shared types and constants for the radix integer-to-ASCII block.
// No dependencies; imported by ritoa_dabble and radix_integer_to_ascii_top.
`default_nettype none

package ritoa_pkg;

    typedef logic [1:0] t_radix_sel;
    typedef logic [3:0] t_digit;
    typedef logic [6:0] t_char;

    localparam t_radix_sel RADIX_BIN = 2'd0;
    localparam t_radix_sel RADIX_DEC = 2'd1;
    localparam t_radix_sel RADIX_HEX = 2'd2;

    localparam t_char ASCII_ZERO  = 7'h30;
    localparam t_char ASCII_LOW_A = 7'h61;
    localparam t_digit DEC_TEN    = 4'd10;

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char c;
        if (d < DEC_TEN) begin
            c = ASCII_ZERO + {3'b000, d};
        end else begin
            c = ASCII_LOW_A - {3'b000, DEC_TEN} + {3'b000, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/ritoa_dabble.sv]
// ritoa_dabble: one shift-and-add-3 step of binary-to-BCD conversion.
// Depends on ritoa_pkg; used by radix_integer_to_ascii_top.
`default_nettype none

module ritoa_dabble
    import ritoa_pkg::*;
#(
    parameter int NUM_DIGITS = 20
) (
    input  wire logic [4*NUM_DIGITS-1:0] i_bcd,
    input  wire logic                    i_bit,
    output logic      [4*NUM_DIGITS-1:0] o_bcd
);

    logic [4*NUM_DIGITS-1:0] adj;

    // digits of five or more get +3 so the following doubling carries right
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = i_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = i_bcd[4*k +: 4];
            end
        end
    end

    assign o_bcd = {adj[4*NUM_DIGITS-2:0], i_bit};

endmodule

`default_nettype wire

[rtl/radix_integer_to_ascii_top.sv]
// radix_integer_to_ascii_top: converts an unsigned integer to ASCII digits, MSB first.
// Depends on ritoa_pkg and ritoa_dabble.
//
//   channel | direction | signals                          | handshake
//   --------+-----------+----------------------------------+-----------------
//   request | in        | i_value, i_radix_select          | i_valid / o_stall
//   digit   | out       | o_digit_char, o_last             | o_valid / i_stall
//
// Binary and hex requests load straight into the digit register; decimal first runs
// double dabble in S_CONV through the shared ritoa_dabble step, one input bit per step.
// Emission in S_EMIT then shifts out suppressed leading zeros without output, loads
// each remaining digit into the output register when it is free, and waits on stalls.
// o_stall is high from acceptance until the last digit enters the output register.
// Reset is synchronous, active low, and clears the sequencer and output valid.
`default_nettype none

module radix_integer_to_ascii_top
    import ritoa_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_radix_select,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_digit_char,
    output logic             o_last
);

    localparam int NUM_DEC = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NUM_HEX = (VALUE_BITS + 3) / 4;
    localparam int DW      = 4 * NUM_DEC;
    localparam int CW      = $clog2(DW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            r_state;
    logic [VALUE_BITS-1:0] r_bin;
    logic [DW-1:0]         r_dig;
    logic [CW-1:0]         r_cnt;
    logic                  r_wide;
    logic                  r_lead;
    logic                  r_ov;
    t_char                 r_char;
    logic                  r_last;

    logic [VALUE_BITS-1:0] val;
    logic [4*NUM_HEX-1:0]  hex_pad;
    logic [DW-1:0]         dd_next;
    logic [DW-1:0]         dig_shift;
    t_digit                top_digit;
    logic                  out_free;
    logic                  skip_zero;
    logic                  fire;

    assign val     = i_value[VALUE_BITS-1:0];
    assign hex_pad = (4*NUM_HEX)'(val);

    ritoa_dabble #(
        .NUM_DIGITS(NUM_DEC)
    ) u_dabble (
        .i_bcd(r_dig),
        .i_bit(r_bin[VALUE_BITS-1]),
        .o_bcd(dd_next)
    );

    assign top_digit = r_wide ? r_dig[DW-1 -: 4] : {3'b000, r_dig[DW-1]};
    assign dig_shift = r_wide ? (r_dig << 4) : (r_dig << 1);
    assign out_free  = !r_ov || !i_stall;
    assign skip_zero = r_lead && (top_digit == 4'd0) && (r_cnt > CW'(1));
    assign fire      = (r_state == S_EMIT) && !skip_zero && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_lead <= 1'b1;
                        unique case (i_radix_select)
                            RADIX_BIN: begin
                                r_dig   <= DW'(val) << (DW - VALUE_BITS);
                                r_cnt   <= CW'(VALUE_BITS);
                                r_wide  <= 1'b0;
                                r_state <= S_EMIT;
                            end
                            RADIX_DEC: begin
                                r_bin   <= val;
                                r_dig   <= '0;
                                r_cnt   <= CW'(VALUE_BITS);
                                r_wide  <= 1'b1;
                                r_state <= S_CONV;
                            end
                            default: begin
                                r_dig   <= DW'(hex_pad) << (DW - 4*NUM_HEX);
                                r_cnt   <= CW'(NUM_HEX);
                                r_wide  <= 1'b1;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_dig <= dd_next;
                    r_bin <= r_bin << 1;
                    if (r_cnt == CW'(1)) begin
                        r_cnt   <= CW'(NUM_DEC);
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_EMIT: begin
                    if (skip_zero || fire) begin
                        r_dig <= dig_shift;
                        r_cnt <= r_cnt - CW'(1);
                    end
                    if (fire) begin
                        r_lead <= 1'b0;
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output payload, loaded only when the slot is free
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char <= digit_to_ascii(top_digit);
            r_last <= (r_cnt == CW'(1));
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ov;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[rtl/ritoa_chk.sv]
// ritoa_chk: port-level checks for radix_integer_to_ascii_top, bound to the top level.
// Depends on radix_integer_to_ascii_top's ports only.
`default_nettype none

module ritoa_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [6:0]  o_digit_char,
    input wire logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digit_char) && $stable(o_last)))
        else $error("output changed while stalled");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= 7'h30 && o_digit_char <= 7'h39) ||
                     (o_digit_char >= 7'h61 && o_digit_char <= 7'h66)))
        else $error("digit character out of range");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted but block not busy");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && o_valid) |-> o_last)
        else $error("idle with a non-final digit pending");

endmodule

bind radix_integer_to_ascii_top ritoa_chk u_ritoa_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_digit_char(o_digit_char),
    .o_last(o_last)
);

`default_nettype wire

[tb/ritoa_digit_check.sv]
// ritoa_digit_check: watches the request and digit channels of the integer-to-ASCII block,
// predicts the digit string of every accepted request and compares each digit as it leaves.
// Depends on ritoa_pkg for the radix codes and ASCII constants.
`timescale 1ns / 100ps

module ritoa_digit_check
    import ritoa_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_radix_select,
    input  wire logic        i_dig_valid,
    input  wire logic        i_dig_stall,
    input  wire logic [6:0]  i_digit_char,
    input  wire logic        i_last,
    output int               o_pending,
    output int               o_mismatches
);

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_digit_out;

    t_digit_out due_digits [$];
    int         mismatches = 0;

    assign o_mismatches = mismatches;

    // Digits of one request, most significant first, appended to the outstanding list.
    function automatic void queue_digits_of(input logic [63:0] value, input t_radix_sel sel);
        logic [63:0] rest;
        logic [63:0] base;
        logic [63:0] rem;
        logic [63:0] mask;
        t_digit      d;
        t_digit      stack [$];
        t_digit_out  item;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        rest = value & mask;
        if (sel == RADIX_BIN) begin
            base = 64'd2;
        end else if (sel == RADIX_DEC) begin
            base = 64'd10;
        end else begin
            base = 64'd16;  // code three falls into hex as well
        end
        do begin
            rem = rest % base;
            stack.push_front(rem[3:0]);
            rest = rest / base;
        end while (rest != 64'd0);
        while (stack.size() > 0) begin
            d = stack.pop_front();
            if (d < DEC_TEN) begin
                item.ch = ASCII_ZERO + {3'b000, d};
            end else begin
                item.ch = ASCII_LOW_A + {3'b000, d} - {3'b000, DEC_TEN};
            end
            item.last = (stack.size() == 0);
            due_digits.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_out want;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                queue_digits_of(i_value, i_radix_select);
            end
            if (i_dig_valid && !i_dig_stall) begin
                if (due_digits.size() == 0) begin
                    mismatches++;
                    $display("%0t: digit expected none, actual char %h last %b",
                             $time, i_digit_char, i_last);
                end else begin
                    want = due_digits.pop_front();
                    if (i_digit_char !== want.ch) begin
                        mismatches++;
                        $display("%0t: digit_char expected %h, actual %h",
                                 $time, want.ch, i_digit_char);
                    end
                    if (i_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b, actual %b",
                                 $time, want.last, i_last);
                    end
                end
            end
        end
        o_pending <= due_digits.size();
    end

endmodule

[tb/radix_integer_to_ascii_top_tb.sv]
// radix_integer_to_ascii_top_tb: drives directed and random conversion requests with random
// idle and stall cycles into the block; ritoa_digit_check predicts and compares the digits.
// Depends on ritoa_pkg, radix_integer_to_ascii_top and ritoa_digit_check.
`timescale 1ns / 100ps

module radix_integer_to_ascii_top_tb;
    import ritoa_pkg::*;

    localparam int         VALUE_BITS   = 64;
    localparam int         RANDOM_REQS  = 470;
    localparam int         CYCLE_LIMIT  = 3_000_000;
    localparam int         DRAIN_CYCLES = 2 * VALUE_BITS + 20;
    localparam t_radix_sel RADIX_CODE3  = 2'd3;  // unassigned code, behaves as hex

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [63:0] i_value        = '0;
    logic [1:0]  i_radix_select = RADIX_BIN;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [6:0]  o_digit_char;
    logic        o_last;

    int pending;
    int mismatches;
    int cycles       = 0;
    int stall_left   = 0;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;

    always #4 i_clk = ~i_clk;

    radix_integer_to_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_radix_select(i_radix_select),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digit_char  (o_digit_char),
        .o_last        (o_last)
    );

    ritoa_digit_check #(
        .VALUE_BITS(VALUE_BITS)
    ) digit_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_value       (i_value),
        .i_radix_select(i_radix_select),
        .i_dig_valid   (o_valid),
        .i_dig_stall   (i_stall),
        .i_digit_char  (o_digit_char),
        .i_last        (o_last),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    // Digit sink: after each taken digit, hold off for a random count unless in a quiet stretch.
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (o_valid && !i_stall) begin
            if ($urandom_range(0, 29) == 0) begin
                rx_quiet <= ~rx_quiet;
            end
            hold = rx_quiet ? 0 : $urandom_range(0, 12);
            i_stall    <= (hold > 0);
            stall_left <= (hold > 0) ? hold - 1 : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input logic [63:0] value, input t_radix_sel sel);
        int gap;
        if ($urandom_range(0, 24) == 0) begin
            tx_quiet = ~tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_value        <= value;
        i_radix_select <= sel;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    initial begin
        logic [63:0] raw;
        int          width;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero and all-ones in every radix code
        send_request(64'd0, RADIX_BIN);
        send_request(64'd0, RADIX_DEC);
        send_request(64'd0, RADIX_HEX);
        send_request(64'd0, RADIX_CODE3);
        send_request('1, RADIX_BIN);
        send_request('1, RADIX_DEC);
        send_request('1, RADIX_HEX);
        send_request('1, RADIX_CODE3);
        // single digits and digit-count boundaries
        send_request(64'd1, RADIX_BIN);
        send_request(64'd1, RADIX_DEC);
        send_request(64'd9, RADIX_DEC);
        send_request(64'd10, RADIX_DEC);
        send_request(64'd15, RADIX_HEX);
        send_request(64'd16, RADIX_HEX);
        send_request(64'd255, RADIX_BIN);
        send_request(64'h8000_0000_0000_0000, RADIX_BIN);
        send_request(64'd10_000_000_000_000_000_000, RADIX_DEC);
        send_request(64'd9_999_999_999, RADIX_DEC);
        send_request(64'h0123_4567_89ab_cdef, RADIX_HEX);
        send_request(64'hdead_beef_cafe_f00d, RADIX_HEX);
        send_request(64'hfedc_ba98_7654_3210, RADIX_CODE3);

        // random widths keep most values short while still reaching the top bits
        for (int n = 0; n < RANDOM_REQS; n++) begin
            raw   = {$urandom, $urandom};
            width = $urandom_range(0, 64);
            if (width < 64) begin
                raw = raw & ((64'd1 << width) - 64'd1);
            end
            send_request(raw, t_radix_sel'($urandom_range(0, 3)));
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
